### hw/rtl/sine_taylor_recurrence_core_defines.svh
// ----------------------------------------------------------------------------
// sine taylor recurrence core: assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef SINE_TAYLOR_RECURRENCE_CORE_DEFINES_SVH
`define SINE_TAYLOR_RECURRENCE_CORE_DEFINES_SVH

// same-cycle implication under reset
`define STC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stc check failed");

// next-cycle implication under reset
`define STC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stc check failed");

`endif

### hw/rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// widths, constants and helper functions of the taylor sine core
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  localparam int MAX_TERMS = 16;
  localparam int TERM_W    = $clog2(MAX_TERMS + 1);

  // divisor (2n-1)(2n-2) stays below 4096 for up to 32 terms
  localparam int REM_W     = 12;

  localparam int DIV_CELLS = 4;
  localparam int DIV_W     = 80;
  localparam int DIV_STEPS = DIV_W / DIV_CELLS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int ACC_W     = 125;
  localparam int MAG_W     = 63;

  localparam logic [31:0]      TWO_PI_Q24 = 32'd105414357;
  localparam logic [MAG_W-1:0] SAT_MAG    = {MAG_W{1'b1}};

  localparam logic CFG_IDX_REL_THRESHOLD = 1'b0;
  localparam logic CFG_IDX_RANGE_REDUCE  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] den;
  } stc_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stc_div_stat_t;

  function automatic logic [REM_W-1:0] term_den(input logic [TERM_W-1:0] n);
    logic [TERM_W+1:0]     a;
    logic [TERM_W+1:0]     b;
    logic [2*TERM_W+3:0]   p;
    a = {n, 1'b0} - (TERM_W+2)'(1);
    b = {n, 1'b0} - (TERM_W+2)'(2);
    p = a * b;
    return REM_W'(p);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/stc_div_cell.sv
// ----------------------------------------------------------------------------
// stc_div_cell
// one restoring division step on the running remainder
// ----------------------------------------------------------------------------
`default_nettype none

module stc_div_cell import stc_pkg::*; (
  input  logic [REM_W-1:0] rem_i,
  input  logic             bit_i,
  input  logic [REM_W-1:0] den_i,
  output logic [REM_W-1:0] rem_o,
  output logic             q_o
);

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;

  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, den_i};
  assign q_o   = trial >= {1'b0, den_i};
  assign rem_o = q_o ? diff[REM_W-1:0] : trial[REM_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/stc_divider.sv
// ----------------------------------------------------------------------------
// stc_divider
// row of restoring cells, several quotient bits per cycle while busy
// ----------------------------------------------------------------------------
`default_nettype none

module stc_divider import stc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stc_div_ctrl_t     ctrl_i,
  input  logic [DIV_W-1:0]  dividend_i,
  output stc_div_stat_t     stat_o,
  output logic [DIV_W-1:0]  quot_o
);

  logic [DIV_W-1:0]  work_q, work_d;
  logic [REM_W-1:0]  rem_q;
  logic [REM_W-1:0]  den_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;

  logic [REM_W-1:0]     rem_chain [DIV_CELLS+1];
  logic [DIV_CELLS-1:0] qbits;

  assign rem_chain[0] = rem_q;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
    stc_div_cell u_cell (
      .rem_i (rem_chain[k]),
      .bit_i (work_q[DIV_W-1-k]),
      .den_i (den_q),
      .rem_o (rem_chain[k+1]),
      .q_o   (qbits[DIV_CELLS-1-k])
    );
  end

  // dividend bits leave at the top, quotient bits enter at the bottom
  assign work_d = {work_q[DIV_W-1-DIV_CELLS:0], qbits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      den_q  <= ctrl_i.den;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_chain[DIV_CELLS];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = work_q;

endmodule

`default_nettype wire

### hw/rtl/sine_taylor_recurrence_core.sv
// ----------------------------------------------------------------------------
// sine_taylor_recurrence_core
// Taylor series sine by term recurrence, Q8.24 angle in, Q2.30 sine out.
// Setup optionally range-reduces the angle by subtracting 2*pi times powers
// of two, then squares it; each later term is the last one times the square,
// divided by (2n-1)(2n-2) in the divider row, on one shared 32x32 multiplier.
// One angle at a time; the next is taken once the result is in the output
// register. Reset clears control and sets the configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_taylor_recurrence_core import stc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] sine_o,
  output logic [4:0]         terms_used_o,
  output logic               overflow_o
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] ST_RED   = 4'd1;
  localparam logic [ST_W-1:0] ST_CHK   = 4'd2;
  localparam logic [ST_W-1:0] ST_SQ    = 4'd3;
  localparam logic [ST_W-1:0] ST_SQW   = 4'd4;
  localparam logic [ST_W-1:0] ST_TMUL  = 4'd5;
  localparam logic [ST_W-1:0] ST_TACC  = 4'd6;
  localparam logic [ST_W-1:0] ST_DIVS  = 4'd7;
  localparam logic [ST_W-1:0] ST_DIV   = 4'd8;
  localparam logic [ST_W-1:0] ST_ADD   = 4'd9;
  localparam logic [ST_W-1:0] ST_THMUL = 4'd10;
  localparam logic [ST_W-1:0] ST_THACC = 4'd11;
  localparam logic [ST_W-1:0] ST_CMP   = 4'd12;
  localparam logic [ST_W-1:0] ST_FIN   = 4'd13;

  logic [ST_W-1:0]    state_q, state_d;
  logic [31:0]        thr_q;
  logic               reduce_q;

  logic [31:0]        ax_q;
  logic               neg_q;
  logic [2:0]         red_cnt_q;
  logic [63:0]        sq_q;
  logic [MAG_W-1:0]   term_mag_q;
  logic               term_neg_q;
  logic signed [63:0] sum_q;
  logic               ovf_q;
  logic [TERM_W-1:0]  n_q;
  logic [1:0]         part_q;
  logic [ACC_W-1:0]   acc_q;
  logic [63:0]        pp_q;

  logic               out_valid_q;
  logic signed [31:0] sine_q;
  logic [4:0]         terms_q;
  logic               ovf_out_q;

  logic               in_acc, can_load;
  logic [31:0]        mul_a, mul_b;
  logic [ACC_W-1:0]   pp_shifted;
  logic [31:0]        red_sub;
  logic [55:0]        t0;
  logic [MAG_W-1:0]   sum_mag;
  logic               q_high;
  logic signed [64:0] term_val, sum_wide;
  logic               stop;
  logic               last_term;
  logic [44:0]        sh;
  logic [31:0]        sh32;
  logic               sh_sat;
  logic signed [31:0] sine_res;

  stc_div_ctrl_t      div_ctrl;
  stc_div_stat_t      div_stat;
  logic [DIV_W-1:0]   div_quot;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_q || !out_stall_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= 32'd4295;
      reduce_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_REL_THRESHOLD: thr_q    <= cfg_data_i;
        CFG_IDX_RANGE_REDUCE:  reduce_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      ST_TMUL: begin
        mul_a = part_q[0] ? {1'b0, term_mag_q[62:32]} : term_mag_q[31:0];
        mul_b = part_q[1] ? sq_q[63:32] : sq_q[31:0];
      end
      ST_THMUL: begin
        mul_a = part_q[0] ? {1'b0, sum_mag[62:32]} : sum_mag[31:0];
        mul_b = thr_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (2'(part_q[0]) + 2'(part_q[1]))
      2'd0:    pp_shifted = ACC_W'(pp_q);
      2'd1:    pp_shifted = ACC_W'({pp_q, 32'b0});
      default: pp_shifted = ACC_W'({pp_q, 64'b0});
    endcase
  end

  assign red_sub  = TWO_PI_Q24 << red_cnt_q;
  assign t0       = {ax_q, 24'b0};
  assign sum_mag  = MAG_W'(sum_q[63] ? -sum_q : sum_q);
  assign q_high   = |div_quot[DIV_W-1:MAG_W];
  assign term_val = term_neg_q ? -$signed({2'b00, term_mag_q}) : $signed({2'b00, term_mag_q});
  assign sum_wide = {sum_q[63], sum_q} + term_val;
  assign stop     = {term_mag_q, 32'b0} <= acc_q[94:0];
  assign last_term = stop || (n_q == TERM_W'(MAX_TERMS));

  // final scaling to Q2.30 with saturation
  assign sh       = sum_mag[62:18];
  assign sh_sat   = sum_q[63] ? (sh > 45'h0_8000_0000) : (sh > 45'h0_7FFF_FFFF);
  assign sh32     = sh_sat ? (sum_q[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sh[31:0];
  assign sine_res = sum_q[63] ? $signed(32'd0 - sh32) : $signed(sh32);

  assign div_ctrl.start = (state_q == ST_DIVS);
  assign div_ctrl.den   = term_den(n_q);

  stc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (DIV_W'(acc_q[ACC_W-1:48])),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = reduce_q ? ST_RED : ST_CHK;
      ST_RED:   if (red_cnt_q == 3'd0) state_d = ST_CHK;
      ST_CHK:   state_d = (ax_q == 32'd0) ? ST_FIN : ST_SQ;
      ST_SQ:    state_d = ST_SQW;
      ST_SQW:   state_d = ST_TMUL;
      ST_TMUL:  state_d = ST_TACC;
      ST_TACC:  state_d = (part_q == 2'd3) ? ST_DIVS : ST_TMUL;
      ST_DIVS:  state_d = ST_DIV;
      ST_DIV:   if (div_stat.done) state_d = ST_ADD;
      ST_ADD:   state_d = ST_THMUL;
      ST_THMUL: state_d = ST_THACC;
      ST_THACC: state_d = part_q[0] ? ST_CMP : ST_THMUL;
      ST_CMP:   state_d = last_term ? ST_FIN : ST_TMUL;
      ST_FIN:   if (can_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && can_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    pp_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_q     <= angle_i[31];
          ax_q      <= angle_i[31] ? 32'd0 - angle_i : angle_i;
          red_cnt_q <= 3'd4;
          ovf_q     <= 1'b0;
        end
      end
      ST_RED: begin
        if (ax_q >= red_sub) ax_q <= ax_q - red_sub;
        red_cnt_q <= red_cnt_q - 3'd1;
      end
      ST_CHK: begin
        term_mag_q <= MAG_W'(t0);
        term_neg_q <= neg_q;
        sum_q      <= neg_q ? -$signed(64'(t0)) : $signed(64'(t0));
        n_q        <= (ax_q == 32'd0) ? TERM_W'(1) : TERM_W'(2);
        part_q     <= 2'd0;
        acc_q      <= '0;
      end
      ST_SQW: sq_q <= pp_q;
      ST_TACC: begin
        acc_q  <= acc_q + pp_shifted;
        part_q <= part_q + 2'd1;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          term_mag_q <= q_high ? SAT_MAG : div_quot[MAG_W-1:0];
          term_neg_q <= !term_neg_q;
          if (q_high) ovf_q <= 1'b1;
        end
      end
      ST_ADD: begin
        // symmetric saturation of the running sum
        if (sum_wide > $signed({2'b00, SAT_MAG})) begin
          sum_q <= $signed({1'b0, SAT_MAG});
          ovf_q <= 1'b1;
        end else if (sum_wide < -$signed({2'b00, SAT_MAG})) begin
          sum_q <= -$signed({1'b0, SAT_MAG});
          ovf_q <= 1'b1;
        end else begin
          sum_q <= sum_wide[63:0];
        end
        acc_q  <= '0;
        part_q <= 2'd0;
      end
      ST_THACC: begin
        acc_q  <= acc_q + pp_shifted;
        part_q <= part_q + 2'd1;
      end
      ST_CMP: begin
        // the count holds the last term summed
        if (!last_term) n_q <= n_q + TERM_W'(1);
        acc_q  <= '0;
        part_q <= 2'd0;
      end
      ST_FIN: begin
        if (can_load) begin
          sine_q    <= sine_res;
          terms_q   <= 5'(n_q);
          ovf_out_q <= ovf_q || sh_sat;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sine_o       = sine_q;
  assign terms_used_o = terms_q;
  assign overflow_o   = ovf_out_q;

endmodule

`default_nettype wire

### hw/rtl/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker
// port-level checks of the taylor sine core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "sine_taylor_recurrence_core_defines.svh"

module stc_checker import stc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic               cfg_idx_i,
  input logic [31:0]        cfg_data_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic signed [31:0] angle_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] sine_o,
  input logic [4:0]         terms_used_o,
  input logic               overflow_o
);

  logic unused_ok;
  assign unused_ok = cfg_we_i ^ cfg_idx_i ^ (^cfg_data_i) ^ (^angle_i);

  // a held result beat stays offered
  `STC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // an accepted angle keeps the block busy in the next cycle
  `STC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a single term only comes from an angle that is zero after range reduction, giving a zero sine without overflow
  `STC_ASSERT_NOW(a_single_term_zero, clk_i, rst_ni, out_valid_o && terms_used_o == 5'd1,
                  sine_o == 32'sd0 && !overflow_o)

  // the term count never reads zero below the full width
  `STC_ASSERT_NOW(a_terms_nonzero, clk_i, rst_ni, out_valid_o,
                  terms_used_o != 5'd0 || MAX_TERMS >= 32)

endmodule

bind sine_taylor_recurrence_core stc_checker u_stc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .angle_i      (angle_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sine_o       (sine_o),
  .terms_used_o (terms_used_o),
  .overflow_o   (overflow_o)
);

`default_nettype wire
